// File: hw/rtl/cau_pkg.sv
package cau_pkg;

   localparam int DATA_W        = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int QUOT_W        = 32;
   localparam int MAG_W         = 65;
   localparam int DEN_W         = 64;
   localparam int REM_W         = 96;

   localparam logic [2:0] FUNC_ADD  = 3'd0;
   localparam logic [2:0] FUNC_SUB  = 3'd1;
   localparam logic [2:0] FUNC_MUL  = 3'd2;
   localparam logic [2:0] FUNC_DIV  = 3'd3;
   localparam logic [2:0] FUNC_SCL  = 3'd4;
   localparam logic [2:0] FUNC_NORM = 3'd5;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DZ  = 2'd2;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic        is_div;
      logic        dz;
      logic        neg_re;
      logic        neg_im;
      logic        ovf_re;
      logic        ovf_im;
      logic        sat;
      logic [31:0] res_re;
      logic [31:0] res_im;
   } side_type;

   // truncated magnitude to signed 32 bit with clamp, returns {sat, value}
   function automatic logic [32:0] narrow(input logic neg, input logic [MAG_W-1:0] m);
      logic [31:0] low;
      logic [32:0] res;
      low = m[31:0];
      if (!neg) begin
         if (m > MAG_W'(32'h7FFF_FFFF)) res = {1'b1, 32'h7FFF_FFFF};
         else res = {1'b0, low};
      end else begin
         if (m > MAG_W'(32'h8000_0000)) res = {1'b1, 32'h8000_0000};
         else res = {1'b0, 32'd0 - low};
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/cau_front.sv
module cau_front #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  cau_pkg::req_type                in_item,
   output logic                            out_valid,
   output cau_pkg::side_type               out_side,
   output logic [cau_pkg::REM_W-1:0]       out_r_re,
   output logic [cau_pkg::REM_W-1:0]       out_r_im,
   output logic [cau_pkg::DEN_W-1:0]       out_den
);

   function automatic logic [65:0] sx32(input logic [31:0] v);
      return {{34{v[31]}}, v};
   endfunction

   function automatic logic [65:0] sx64(input logic [63:0] v);
      return {{2{v[63]}}, v};
   endfunction

   // stage 1: operand capture
   logic             v1_ff;
   cau_pkg::req_type r1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
      r1_ff <= in_item;
   end

   // stage 2: products
   logic                v2_ff;
   cau_pkg::req_type    r2_ff;
   logic signed [63:0]  p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [63:0]  p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   logic signed [31:0]  op4, op5;
   logic                is_norm1;

   always_comb begin
      is_norm1 = (r1_ff.func == cau_pkg::FUNC_NORM);
      op4      = is_norm1 ? r1_ff.a_re : r1_ff.b_re;
      op5      = is_norm1 ? r1_ff.a_im : r1_ff.b_im;
      p0_in    = r1_ff.a_re * r1_ff.b_re;
      p1_in    = r1_ff.a_im * r1_ff.b_im;
      p2_in    = r1_ff.a_re * r1_ff.b_im;
      p3_in    = r1_ff.a_im * r1_ff.b_re;
      p4_in    = op4 * op4;
      p5_in    = op5 * op5;
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      r2_ff <= r1_ff;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      p3_ff <= p3_in;
      p4_ff <= p4_in;
      p5_ff <= p5_in;
   end

   // stage 3: sums, sign and magnitude
   logic                       v3_ff;
   logic [2:0]                 func3_ff;
   logic                       neg_re_ff, neg_im_ff;
   logic [cau_pkg::MAG_W-1:0]  mag_re_ff, mag_im_ff;
   logic [cau_pkg::DEN_W-1:0]  den_ff;
   logic [65:0]                sum_re, sum_im, nsum_re, nsum_im;
   logic [cau_pkg::MAG_W-1:0]  mag_re_in, mag_im_in;
   logic [cau_pkg::DEN_W-1:0]  den_in;

   always_comb begin
      sum_re = '0;
      sum_im = '0;
      unique case (r2_ff.func)
         cau_pkg::FUNC_ADD: begin
            sum_re = sx32(r2_ff.a_re) + sx32(r2_ff.b_re);
            sum_im = sx32(r2_ff.a_im) + sx32(r2_ff.b_im);
         end
         cau_pkg::FUNC_SUB: begin
            sum_re = sx32(r2_ff.a_re) - sx32(r2_ff.b_re);
            sum_im = sx32(r2_ff.a_im) - sx32(r2_ff.b_im);
         end
         cau_pkg::FUNC_MUL: begin
            sum_re = sx64(p0_ff) - sx64(p1_ff);
            sum_im = sx64(p2_ff) + sx64(p3_ff);
         end
         cau_pkg::FUNC_DIV: begin
            sum_re = sx64(p0_ff) + sx64(p1_ff);
            sum_im = sx64(p3_ff) - sx64(p2_ff);
         end
         cau_pkg::FUNC_SCL: begin
            sum_re = sx64(p0_ff);
            sum_im = sx64(p3_ff);
         end
         cau_pkg::FUNC_NORM: begin
            sum_re = sx64(p4_ff) + sx64(p5_ff);
            sum_im = '0;
         end
         default: begin
            sum_re = '0;
            sum_im = '0;
         end
      endcase
      nsum_re   = 66'd0 - sum_re;
      nsum_im   = 66'd0 - sum_im;
      mag_re_in = sum_re[65] ? nsum_re[cau_pkg::MAG_W-1:0] : sum_re[cau_pkg::MAG_W-1:0];
      mag_im_in = sum_im[65] ? nsum_im[cau_pkg::MAG_W-1:0] : sum_im[cau_pkg::MAG_W-1:0];
      den_in    = p4_ff + p5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      func3_ff  <= r2_ff.func;
      neg_re_ff <= sum_re[65];
      neg_im_ff <= sum_im[65];
      mag_re_ff <= mag_re_in;
      mag_im_ff <= mag_im_in;
      den_ff    <= den_in;
   end

   // stage 4: narrowing for the direct paths, dividend setup for divide
   logic                       v4_ff;
   cau_pkg::side_type          side_ff, side_in;
   logic [cau_pkg::REM_W-1:0]  r_re_ff, r_im_ff, r_re_in, r_im_in, dsh;
   logic [cau_pkg::DEN_W-1:0]  den4_ff;
   logic [cau_pkg::MAG_W-1:0]  sh_re, sh_im;
   logic [32:0]                nr_re, nr_im;
   logic                       no_shift;

   always_comb begin
      no_shift = (func3_ff == cau_pkg::FUNC_ADD) || (func3_ff == cau_pkg::FUNC_SUB);
      sh_re    = no_shift ? mag_re_ff : (mag_re_ff >> FRAC_BITS);
      sh_im    = no_shift ? mag_im_ff : (mag_im_ff >> FRAC_BITS);
      nr_re    = cau_pkg::narrow(neg_re_ff, sh_re);
      nr_im    = cau_pkg::narrow(neg_im_ff, sh_im);
      r_re_in  = cau_pkg::REM_W'(mag_re_ff) << FRAC_BITS;
      r_im_in  = cau_pkg::REM_W'(mag_im_ff) << FRAC_BITS;
      dsh      = cau_pkg::REM_W'(den_ff) << cau_pkg::QUOT_W;
      side_in.is_div = (func3_ff == cau_pkg::FUNC_DIV);
      side_in.dz     = (den_ff == '0);
      side_in.neg_re = neg_re_ff;
      side_in.neg_im = neg_im_ff;
      side_in.ovf_re = (r_re_in >= dsh);
      side_in.ovf_im = (r_im_in >= dsh);
      side_in.sat    = nr_re[32] | nr_im[32];
      side_in.res_re = nr_re[31:0];
      side_in.res_im = nr_im[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      side_ff <= side_in;
      r_re_ff <= r_re_in;
      r_im_ff <= r_im_in;
      den4_ff <= den_ff;
   end

   assign out_valid = v4_ff;
   assign out_side  = side_ff;
   assign out_r_re  = r_re_ff;
   assign out_r_im  = r_im_ff;
   assign out_den   = den4_ff;

endmodule

// File: hw/rtl/cau_div.sv
module cau_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  cau_pkg::side_type               in_side,
   input  logic [cau_pkg::REM_W-1:0]       in_r_re,
   input  logic [cau_pkg::REM_W-1:0]       in_r_im,
   input  logic [cau_pkg::DEN_W-1:0]       in_den,
   output logic                            out_valid,
   output cau_pkg::side_type               out_side,
   output logic [cau_pkg::QUOT_W-1:0]      out_q_re,
   output logic [cau_pkg::QUOT_W-1:0]      out_q_im
);

   localparam int N = cau_pkg::QUOT_W;

   logic                          v_ff    [N];
   cau_pkg::side_type             side_ff [N];
   logic [cau_pkg::REM_W-1:0]     r_re_ff [N];
   logic [cau_pkg::REM_W-1:0]     r_im_ff [N];
   logic [cau_pkg::DEN_W-1:0]     d_ff    [N];
   logic [N-1:0]                  q_re_ff [N];
   logic [N-1:0]                  q_im_ff [N];

   // one quotient bit per stage, msb first
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic                       v_prev;
      cau_pkg::side_type          side_prev;
      logic [cau_pkg::REM_W-1:0]  r_re_prev, r_im_prev, dk, t_re, t_im;
      logic [cau_pkg::DEN_W-1:0]  d_prev;
      logic [N-1:0]               q_re_prev, q_im_prev;
      logic                       b_re, b_im;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign side_prev = in_side;
         assign r_re_prev = in_r_re;
         assign r_im_prev = in_r_im;
         assign d_prev    = in_den;
         assign q_re_prev = '0;
         assign q_im_prev = '0;
      end else begin : g_next
         assign v_prev    = v_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign r_re_prev = r_re_ff[s-1];
         assign r_im_prev = r_im_ff[s-1];
         assign d_prev    = d_ff[s-1];
         assign q_re_prev = q_re_ff[s-1];
         assign q_im_prev = q_im_ff[s-1];
      end

      always_comb begin
         dk   = cau_pkg::REM_W'(d_prev) << (N - 1 - s);
         b_re = (r_re_prev >= dk);
         b_im = (r_im_prev >= dk);
         t_re = b_re ? r_re_prev - dk : r_re_prev;
         t_im = b_im ? r_im_prev - dk : r_im_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else v_ff[s] <= v_prev;
         side_ff[s] <= side_prev;
         r_re_ff[s] <= t_re;
         r_im_ff[s] <= t_im;
         d_ff[s]    <= d_prev;
         q_re_ff[s] <= {q_re_prev[N-2:0], b_re};
         q_im_ff[s] <= {q_im_prev[N-2:0], b_im};
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_side  = side_ff[N-1];
   assign out_q_re  = q_re_ff[N-1];
   assign out_q_im  = q_im_ff[N-1];

endmodule

// File: hw/rtl/complex_arithmetic_unit.sv
// Pipelined complex ALU on signed fixed point operands. A transaction is taken on
// every cycle that start is high; busy is always low because the pipeline never
// stalls. Every transaction, whatever its function code, returns its result in
// order, on a single-cycle rsp_valid strobe, after passing through the operand
// capture, multiply, sum and narrowing stages, the restoring divider that yields
// one quotient bit per stage, and one output register. Results cannot be held off,
// so the receiver must take every strobe.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cau_pkg::req_type  req_item,
   output logic              rsp_valid,
   output cau_pkg::rsp_type  rsp_item
);

   localparam int LATENCY = cau_pkg::QUOT_W + 5;

   logic                          f_valid;
   cau_pkg::side_type             f_side;
   logic [cau_pkg::REM_W-1:0]     f_r_re, f_r_im;
   logic [cau_pkg::DEN_W-1:0]     f_den;
   logic                          d_valid;
   cau_pkg::side_type             d_side;
   logic [cau_pkg::QUOT_W-1:0]    d_q_re, d_q_im;

   assign busy = 1'b0;

   cau_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_item   (req_item),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_r_re  (f_r_re),
      .out_r_im  (f_r_im),
      .out_den   (f_den)
   );

   cau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_r_re   (f_r_re),
      .in_r_im   (f_r_im),
      .in_den    (f_den),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_q_re  (d_q_re),
      .out_q_im  (d_q_im)
   );

   logic                       valid_ff;
   cau_pkg::rsp_type           rsp_ff, rsp_in;
   logic [cau_pkg::MAG_W-1:0]  m_re, m_im;
   logic [32:0]                n_re, n_im;

   always_comb begin
      m_re = d_side.ovf_re ? cau_pkg::MAG_W'(33'h1_0000_0000) : cau_pkg::MAG_W'(d_q_re);
      m_im = d_side.ovf_im ? cau_pkg::MAG_W'(33'h1_0000_0000) : cau_pkg::MAG_W'(d_q_im);
      n_re = cau_pkg::narrow(d_side.neg_re, m_re);
      n_im = cau_pkg::narrow(d_side.neg_im, m_im);
      priority if (d_side.is_div && d_side.dz) begin
         rsp_in.res_re = '0;
         rsp_in.res_im = '0;
         rsp_in.status = cau_pkg::ST_DZ;
      end else if (d_side.is_div) begin
         rsp_in.res_re = n_re[31:0];
         rsp_in.res_im = n_im[31:0];
         rsp_in.status = (n_re[32] | n_im[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end else begin
         rsp_in.res_re = d_side.res_re;
         rsp_in.res_im = d_side.res_im;
         rsp_in.status = d_side.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= d_valid;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transaction result missing at fixed latency");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == cau_pkg::ST_DZ) |->
      (rsp_item.res_re == '0 && rsp_item.res_im == '0))
      else $error("divide by zero result not cleared");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == cau_pkg::ST_OK || rsp_item.status == cau_pkg::ST_SAT
                     || rsp_item.status == cau_pkg::ST_DZ))
      else $error("illegal status code");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == cau_pkg::ST_SAT) |->
      (rsp_item.res_re == 32'sh7FFF_FFFF || rsp_item.res_re == 32'sh8000_0000 ||
       rsp_item.res_im == 32'sh7FFF_FFFF || rsp_item.res_im == 32'sh8000_0000))
      else $error("saturated status without clamped part");

endmodule

// File: test/complex_arithmetic_unit_tb.sv
module complex_arithmetic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cau_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = 37;
   localparam longint CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_item;
   logic rsp_valid;
   rsp_type rsp_item;

   rsp_type alu_results_q[$];
   int errors;
   longint cycle_count;
   bit idle_enable;

   complex_arithmetic_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // clamp a signed 128 bit value to 32 bits
   function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
      if (v > 128'sh7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -128'sh8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // truncating right shift toward zero
   function automatic logic signed [127:0] shr_tz(input logic signed [127:0] v);
      if (v < 0) return -((-v) >>> FB);
      return v >>> FB;
   endfunction

   // numerator * 2^FB / den, toward zero
   function automatic logic signed [127:0] div_tz(input logic signed [127:0] n,
                                                  input logic signed [127:0] d);
      logic signed [127:0] m;
      m = (n < 0) ? -n : n;
      m = (m <<< FB) / d;
      return (n < 0) ? -m : m;
   endfunction

   function automatic rsp_type alu_predict(input req_type r);
      logic signed [127:0] ar, ai, br, bi, re, im, den;
      rsp_type o;
      bit sat;
      ar = r.a_re;
      ai = r.a_im;
      br = r.b_re;
      bi = r.b_im;
      sat = 1'b0;
      o.res_re = '0;
      o.res_im = '0;
      o.status = ST_OK;
      case (r.func)
         FUNC_ADD: begin
            o.res_re = clamp32(ar + br, sat);
            o.res_im = clamp32(ai + bi, sat);
         end
         FUNC_SUB: begin
            o.res_re = clamp32(ar - br, sat);
            o.res_im = clamp32(ai - bi, sat);
         end
         FUNC_MUL: begin
            o.res_re = clamp32(shr_tz(ar * br - ai * bi), sat);
            o.res_im = clamp32(shr_tz(ar * bi + ai * br), sat);
         end
         FUNC_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               o.status = ST_DZ;
            end else begin
               re = div_tz(ar * br + ai * bi, den);
               im = div_tz(ai * br - ar * bi, den);
               o.res_re = clamp32(re, sat);
               o.res_im = clamp32(im, sat);
            end
         end
         FUNC_SCL: begin
            o.res_re = clamp32(shr_tz(ar * br), sat);
            o.res_im = clamp32(shr_tz(ai * br), sat);
         end
         FUNC_NORM: begin
            o.res_re = clamp32(shr_tz(ar * ar + ai * ai), sat);
         end
         default: ;
      endcase
      if (sat && o.status == ST_OK) o.status = ST_SAT;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch %s at cycle %0d: got %h want %h", what, cycle_count, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (alu_results_q.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_item.res_re, 32'd0);
         end else begin
            want = alu_results_q.pop_front();
            if (rsp_item.res_re !== want.res_re)
               report_mismatch("res_re", rsp_item.res_re, want.res_re);
            if (rsp_item.res_im !== want.res_im)
               report_mismatch("res_im", rsp_item.res_im, want.res_im);
            if (rsp_item.status !== want.status)
               report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
         end
      end
   end

   task automatic send_item(input req_type r);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 9);
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      alu_results_q.push_back(alu_predict(r));
      @(negedge clock);
   endtask

   task automatic send_op(input logic [2:0] f, input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi);
      req_type r;
      r.func = f;
      r.a_re = ar;
      r.a_im = ai;
      r.b_re = br;
      r.b_im = bi;
      send_item(r);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
         3: return $urandom_range(0, 32'h200_0000) - 32'h100_0000;
         4: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      start <= 1'b0;
      while (alu_results_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      logic [2:0] f;
      for (int k = 0; k < 8; k++) begin
         f = 3'(k);
         send_op(f, 32'h0001_8000, 32'hFFFE_0000, 32'h0002_0000, 32'h0000_4000);
      end
      send_op(FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      send_op(FUNC_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      send_op(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_op(FUNC_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_op(FUNC_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
      send_op(FUNC_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
      send_op(FUNC_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
      send_op(FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_op(FUNC_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_0000, 32'h0);
      send_op(FUNC_SCL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
      send_op(FUNC_SCL, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_0001, 32'h0);
      send_op(FUNC_NORM, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
      send_op(FUNC_NORM, 32'h0000_B504, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_random(input int count);
      logic [2:0] f;
      logic [31:0] br, bi;
      for (int k = 0; k < count; k++) begin
         f = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
         br = rand_operand();
         bi = rand_operand();
         if (f == FUNC_DIV && $urandom_range(0, 9) == 0) begin
            br = '0;
            bi = '0;
         end
         send_op(f, rand_operand(), rand_operand(), br, bi);
      end
   endtask

   task automatic test_drain_pause();
      wait_drained();
      repeat (3) @(negedge clock);
   endtask

   initial begin
      errors = 0;
      cycle_count = 0;
      idle_enable = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      idle_enable = 1'b1;
      test_random(200);
      test_drain_pause();
      test_random(150);
      idle_enable = 1'b0;
      test_random(100);
      wait_drained();
      repeat (LATENCY + 5) @(negedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

// File: filelist.f
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_div.sv
hw/rtl/complex_arithmetic_unit.sv
test/complex_arithmetic_unit_tb.sv
